FILE: sv/vertex_dedup_table_defines.svh
// Assertion macros shared by the checker of the vertex dedup table.
// Depends on nothing; included by the checker file.
`ifndef VERTEX_DEDUP_TABLE_DEFINES_SVH
`define VERTEX_DEDUP_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define VDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define VDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

FILE: sv/vdt_pkg.sv
// Package for the vertex dedup table: sizes, codes and the quantizer's functions.
// Used by vdt_quant, vdt_hash_table and vertex_dedup_table.
package vdt_pkg;
    localparam int SOURCE_VERTICES = 4096;
    localparam int TABLE_SLOTS = 8192;
    localparam int FRACTION_BITS = 16;
    localparam logic [23:0] SCALE_RESET = 24'd100000;
    localparam int INDEX_SPACE = 4096;
    localparam int KEY_W = 57;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_PROCESS = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_UNLOADED = 2'd2;

    typedef struct packed {
        logic [11:0] out_index;
        logic        is_new;
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] new_z;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0] kx;
        logic [KEY_W-1:0] ky;
        logic [KEY_W-1:0] kz;
    } key_t;

    // Magnitude of a signed Q15.16 coordinate.
    function automatic logic [31:0] coord_mag(input logic [31:0] raw);
        coord_mag = raw[31] ? (~raw + 32'd1) : raw;
    endfunction

    // Round half away from zero and restore the sign.
    function automatic logic [KEY_W-1:0] round_key(input logic [55:0] prod,
                                                  input logic neg, input int fb);
        logic [56:0] q;
        q = ({1'b0, prod} + ((fb > 0) ? (57'd1 << (fb - 1)) : 57'd0)) >> fb;
        round_key = neg ? (~q + 57'd1) : q;
    endfunction
endpackage

FILE: sv/vdt_quant.sv
// Quantizer for one vertex: multiply stage then round stage.
// Depends on vdt_pkg.
module vdt_quant #(
    parameter int FRACTION_BITS = vdt_pkg::FRACTION_BITS
) (
    input  logic                 clk,
    input  logic [31:0]          x,
    input  logic [31:0]          y,
    input  logic [31:0]          z,
    input  logic [23:0]          scale,
    output vdt_pkg::key_t        key
);
    logic [55:0] px_reg, py_reg, pz_reg;
    logic [2:0]  neg_reg;

    // Magnitude times scale, registered.
    always_ff @(posedge clk)
    begin
        px_reg <= {24'd0, vdt_pkg::coord_mag(x)} * {32'd0, scale};
        py_reg <= {24'd0, vdt_pkg::coord_mag(y)} * {32'd0, scale};
        pz_reg <= {24'd0, vdt_pkg::coord_mag(z)} * {32'd0, scale};
        neg_reg <= {x[31], y[31], z[31]};
    end

    // Rounding is combinational behind the product registers.
    always_comb
    begin
        key.kx = vdt_pkg::round_key(px_reg, neg_reg[2], FRACTION_BITS);
        key.ky = vdt_pkg::round_key(py_reg, neg_reg[1], FRACTION_BITS);
        key.kz = vdt_pkg::round_key(pz_reg, neg_reg[0], FRACTION_BITS);
    end
endmodule

FILE: sv/vdt_hash_table.sv
// Hash table memory: epoch marks, keys and compact indexes per slot.
// Depends on vdt_pkg.
module vdt_hash_table #(
    parameter int TABLE_SLOTS = vdt_pkg::TABLE_SLOTS,
    localparam int AW = $clog2(TABLE_SLOTS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    output logic          busy,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_valid,
    output vdt_pkg::key_t rd_key,
    output logic [11:0]   rd_cidx,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  vdt_pkg::key_t wr_key,
    input  logic [11:0]   wr_cidx
);
    // A slot is valid when its epoch mark equals the current epoch. Epoch 0
    // is never live, so a clearing pass that writes 0 empties every slot.
    logic [7:0] epoch_reg;
    logic [7:0] ep_mem [TABLE_SLOTS];
    vdt_pkg::key_t key_mem [TABLE_SLOTS];
    logic [11:0] cidx_mem [TABLE_SLOTS];
    logic [7:0] ep_rd_reg;
    logic        sweep_reg;
    logic [AW-1:0] sweep_addr_reg;

    // Epoch bump on clear; a clearing pass runs after reset and on epoch wrap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= 8'd1;
            sweep_reg <= 1'b1;
            sweep_addr_reg <= '0;
        end
        else if (sweep_reg)
        begin
            if (sweep_addr_reg == AW'(TABLE_SLOTS - 1))
            begin
                sweep_reg <= 1'b0;
                sweep_addr_reg <= '0;
            end
            else
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
        end
        else if (clear)
        begin
            if (epoch_reg == 8'hFF)
            begin
                epoch_reg <= 8'd1;
                sweep_reg <= 1'b1;
            end
            else
            begin
                epoch_reg <= epoch_reg + 8'd1;
            end
        end
    end

    assign busy = sweep_reg;

    // Memory ports: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            ep_mem[sweep_addr_reg] <= 8'd0;
        end
        else if (wr_en)
        begin
            ep_mem[wr_addr] <= epoch_reg;
        end
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            cidx_mem[wr_addr] <= wr_cidx;
        end
        ep_rd_reg <= ep_mem[rd_addr];
        rd_key <= key_mem[rd_addr];
        rd_cidx <= cidx_mem[rd_addr];
    end

    assign rd_valid = (ep_rd_reg == epoch_reg);
endmodule

FILE: sv/vertex_dedup_table.sv
// Vertex welding table. A load (func 0) and a clear (func 2) complete at the
// transfer and leave the sequencer idle. A lookup (func 1) holds the input
// through its steps: source store read, loaded check with the multiply, round,
// hash, then one read and compare per probe on the single table read port,
// until its result is loaded for output. A lookup of an unloaded slot answers
// after the loaded check, without the later steps. Results move into an output
// register, so a stalled result blocks the input only once the next result is
// ready. After reset the input stalls while clearing passes initialize the
// table and the source store, and again on every 255th clear, when the
// table's epoch counter wraps.
// Depends on vdt_pkg, vdt_quant and vdt_hash_table.
module vertex_dedup_table #(
    parameter int SOURCE_VERTICES = vdt_pkg::SOURCE_VERTICES,
    parameter int TABLE_SLOTS = vdt_pkg::TABLE_SLOTS,
    parameter int FRACTION_BITS = vdt_pkg::FRACTION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [11:0] source_index,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic [31:0] coord_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] out_index,
    output logic        is_new,
    output logic [31:0] new_x,
    output logic [31:0] new_y,
    output logic [31:0] new_z,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int SW = $clog2(SOURCE_VERTICES);
    localparam logic [2:0] S_IDLE = 3'd0, S_SRC = 3'd1, S_MUL = 3'd2,
                           S_RND = 3'd3, S_PROBE = 3'd4, S_CMP = 3'd5, S_OUT = 3'd6;

    logic [2:0] state_reg;
    logic [23:0] scale_reg;
    logic [12:0] next_cidx_reg;
    logic [96:0] src_mem [SOURCE_VERTICES];
    logic [96:0] src_rd_reg;
    logic        src_sweep_reg;
    logic [SW-1:0] src_sweep_addr_reg;
    logic [11:0] idx_reg;
    logic        range_ok_reg;
    vdt_pkg::key_t key_reg, qkey;
    logic [AW-1:0] pos_reg;
    logic [AW:0] probes_reg;
    vdt_pkg::result_t res_reg;
    vdt_pkg::result_t out_reg;
    logic tbl_valid;
    logic tbl_busy;
    vdt_pkg::key_t tbl_key;
    logic [11:0] tbl_cidx;
    logic wr_en;
    logic [63:0] h;

    wire accept = in_valid && !in_stall;
    wire in_range = ({20'd0, source_index} < 32'(SOURCE_VERTICES));
    wire out_load = (state_reg == S_OUT) && (!out_valid || !out_stall);
    assign in_stall = (state_reg != S_IDLE) || src_sweep_reg || tbl_busy;
    assign cfg_ready = 1'b1;

    // Clearing pass over the source store after reset marks every slot unloaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_sweep_reg <= 1'b1;
            src_sweep_addr_reg <= '0;
        end
        else if (src_sweep_reg)
        begin
            if (src_sweep_addr_reg == SW'(SOURCE_VERTICES - 1))
            begin
                src_sweep_reg <= 1'b0;
                src_sweep_addr_reg <= '0;
            end
            else
            begin
                src_sweep_addr_reg <= src_sweep_addr_reg + 1'b1;
            end
        end
    end

    // Source store port; the top bit of each entry is its loaded flag.
    always_ff @(posedge clk)
    begin
        if (src_sweep_reg)
        begin
            src_mem[src_sweep_addr_reg] <= '0;
        end
        else if (accept && func == vdt_pkg::FUNC_LOAD && in_range)
        begin
            src_mem[source_index[SW-1:0]] <= {1'b1, coord_x, coord_y, coord_z};
        end
        src_rd_reg <= src_mem[idx_reg[SW-1:0]];
    end

    vdt_quant #(.FRACTION_BITS(FRACTION_BITS)) u_quant (
        .clk(clk), .x(src_rd_reg[95:64]), .y(src_rd_reg[63:32]),
        .z(src_rd_reg[31:0]), .scale(scale_reg), .key(qkey));

    // Any hash works; only key equality decides.
    assign h = {7'd0, key_reg.kx} ^ {key_reg.ky[28:0], 35'd0} ^ {key_reg.kz, 7'd0}
             ^ {key_reg.kz[40:0], 23'd0} ^ {50'd0, key_reg.ky[56:43]};

    wire key_eq = (tbl_key == key_reg);
    assign wr_en = (state_reg == S_CMP) && !tbl_valid && (next_cidx_reg < 13'd4096);

    vdt_hash_table #(.TABLE_SLOTS(TABLE_SLOTS)) u_table (
        .clk(clk), .rst_n(rst_n),
        .clear(accept && func == vdt_pkg::FUNC_CLEAR), .busy(tbl_busy),
        .rd_addr(pos_reg), .rd_valid(tbl_valid), .rd_key(tbl_key), .rd_cidx(tbl_cidx),
        .wr_en(wr_en), .wr_addr(pos_reg), .wr_key(key_reg), .wr_cidx(next_cidx_reg[11:0]));

    // Output register: loads a finished result once the previous one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scale_reg <= vdt_pkg::SCALE_RESET;
            next_cidx_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                scale_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= source_index;
                        range_ok_reg <= in_range;
                        if (func == vdt_pkg::FUNC_CLEAR)
                        begin
                            next_cidx_reg <= '0;
                        end
                        else if (func == vdt_pkg::FUNC_PROCESS)
                        begin
                            state_reg <= S_SRC;
                        end
                    end
                end
                S_SRC: state_reg <= S_MUL;
                S_MUL:
                begin
                    // The source entry is in hand; an unloaded slot answers at once.
                    if (!range_ok_reg || !src_rd_reg[96])
                    begin
                        res_reg <= '{12'd0, 1'b0, 32'd0, 32'd0, 32'd0,
                                     vdt_pkg::ST_UNLOADED};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    key_reg <= qkey;
                    state_reg <= S_PROBE;
                    probes_reg <= '0;
                end
                S_PROBE:
                begin
                    if (probes_reg == 0)
                    begin
                        pos_reg <= h[AW-1:0];
                    end
                    state_reg <= (probes_reg == 0) ? S_PROBE : S_CMP;
                    probes_reg <= (probes_reg == 0) ? {{AW{1'b0}}, 1'b1} : probes_reg;
                end
                S_CMP:
                begin
                    state_reg <= S_OUT;
                    if (!tbl_valid)
                    begin
                        if (next_cidx_reg >= 13'd4096)
                        begin
                            res_reg <= '{12'd0, 1'b0, 32'd0, 32'd0, 32'd0,
                                         vdt_pkg::ST_FULL};
                        end
                        else
                        begin
                            res_reg <= '{next_cidx_reg[11:0], 1'b1, src_rd_reg[95:64],
                                         src_rd_reg[63:32], src_rd_reg[31:0],
                                         vdt_pkg::ST_OK};
                            next_cidx_reg <= next_cidx_reg + 13'd1;
                        end
                    end
                    else if (key_eq)
                    begin
                        res_reg <= '{tbl_cidx, 1'b0, 32'd0, 32'd0, 32'd0, vdt_pkg::ST_OK};
                    end
                    else if (probes_reg == (AW+1)'(TABLE_SLOTS))
                    begin
                        res_reg <= '{12'd0, 1'b0, 32'd0, 32'd0, 32'd0, vdt_pkg::ST_FULL};
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        probes_reg <= probes_reg + 1'b1;
                        state_reg <= S_PROBE;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_index = out_reg.out_index;
    assign is_new = out_reg.is_new;
    assign new_x = out_reg.new_x;
    assign new_y = out_reg.new_y;
    assign new_z = out_reg.new_z;
    assign status = out_reg.status;
endmodule

FILE: sv/vdt_checker.sv
// Port-level checker for the vertex dedup table, bound to the top level.
// Depends on vertex_dedup_table_defines.svh.
`include "vertex_dedup_table_defines.svh"
module vdt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        is_new,
    input logic [1:0]  status,
    input logic [31:0] new_x
);
    // A stalled result holds.
    `VDT_ASSERT_NEXT(hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
    // Status never takes the unused code.
    `VDT_ASSERT_IMP(status_code, clk, rst_n, out_valid, status != 2'd3)
    // An appended vertex always reports ok.
    `VDT_ASSERT_IMP(new_ok, clk, rst_n, out_valid && is_new, status == 2'd0)
    // Error results are not new and carry a zero x coordinate.
    `VDT_ASSERT_IMP(err_zero, clk, rst_n, out_valid && status != 2'd0,
                    !is_new && new_x == 32'd0)
endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .is_new(is_new),
    .status(status), .new_x(new_x));
